/* rtl/package_block_address_translate_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the package block address translator
// Shared property forms for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef PACKAGE_BLOCK_ADDRESS_TRANSLATE_ASSERT_SVH
`define PACKAGE_BLOCK_ADDRESS_TRANSLATE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PBAT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PBAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pbat_pkg.sv */
// ----------------------------------------------------------------------------
// pbat_pkg
// Widths, constants and shared types of the package block address translator.
// ----------------------------------------------------------------------------
package pbat_pkg;

	// Field widths
	localparam int BLK_W   = 24;
	localparam int PHYS_W  = 25;
	localparam int OFFS_W  = 32;
	localparam int HDR_W   = 20;
	localparam int CNT_W   = 16;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 5;
	localparam int REG_IDX_W = ADDR_W - 2;

	// Default block size
	localparam int BLOCK_BYTES_LOG2_DEF = 12;

	// Header alignment (4 KiB) and the header end that forces the doubled terms
	localparam int HDR_ALIGN_LOG2 = 12;
	localparam int HEND_W         = HDR_W + 1;
	localparam int SPECIAL_END    = 32'hB000;
	localparam int PHYS_MAX       = 32'h7F_FFFF;

	// Hash table level spans
	localparam int unsigned LEVEL1 = 32'hAA;
	localparam int unsigned LEVEL2 = LEVEL1 * LEVEL1;
	localparam int unsigned LEVEL3 = LEVEL2 * LEVEL1;

	// Reciprocal constants: q = (blk * M) >> S is exact for blk < 2^BLK_W
	// when S = BLK_W + clog2(d) and M = ceil(2^S / d).
	localparam int RECIP_W = 25;
	localparam int PROD_W  = BLK_W + RECIP_W;
	localparam int RSH1 = BLK_W + $clog2(LEVEL1);
	localparam int RSH2 = BLK_W + $clog2(LEVEL2);
	localparam int RSH3 = BLK_W + $clog2(LEVEL3);
	localparam logic [63:0] RECIP1_FULL =
		((64'd1 << RSH1) + 64'(LEVEL1) - 64'd1) / 64'(LEVEL1);
	localparam logic [63:0] RECIP2_FULL =
		((64'd1 << RSH2) + 64'(LEVEL2) - 64'd1) / 64'(LEVEL2);
	localparam logic [63:0] RECIP3_FULL =
		((64'd1 << RSH3) + 64'(LEVEL3) - 64'd1) / 64'(LEVEL3);
	localparam logic [RECIP_W-1:0] RECIP1 = RECIP1_FULL[RECIP_W-1:0];
	localparam logic [RECIP_W-1:0] RECIP2 = RECIP2_FULL[RECIP_W-1:0];
	localparam logic [RECIP_W-1:0] RECIP3 = RECIP3_FULL[RECIP_W-1:0];

	// Level term width: largest term is 2 * (blk/170 + 1)
	localparam int TERM_W = 18;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_HEADER_LENGTH     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CONSOLE_SIGNED    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SEPARATION_BIT    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TABLE_BLOCK_RAW   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TABLE_BLOCK_COUNT = 3'd4;

	// Settings as seen by the datapath
	typedef struct packed {
		logic [HEND_W-1:0] header_end;
		logic              term_double;
		logic [BLK_W-1:0]  table_block_raw;
		logic [CNT_W-1:0]  table_block_count;
	} cfg_t;

	// Level quotients
	typedef struct packed {
		logic [TERM_W-1:0] q1;
		logic [TERM_W-1:0] q2;
		logic [TERM_W-1:0] q3;
	} quot_t;

endpackage

/* rtl/pbat_regs.sv */
// ----------------------------------------------------------------------------
// pbat_regs
// Configuration register file on the APB-style port, plus the derived
// header end and term doubling decision.
// ----------------------------------------------------------------------------
module pbat_regs
	import pbat_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	logic [HDR_W-1:0] header_length_q;
	logic             console_signed_q;
	logic             separation_bit_q;
	logic [BLK_W-1:0] table_block_raw_q;
	logic [CNT_W-1:0] table_block_count_q;

	logic [REG_IDX_W-1:0]          reg_idx;
	logic                          wr_en;
	logic [HDR_W-HDR_ALIGN_LOG2:0] hdr_pages;
	logic [HEND_W-1:0]             header_end;
	logic                          shift_one;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_length_q     <= '0;
			console_signed_q    <= 1'b0;
			separation_bit_q    <= 1'b0;
			table_block_raw_q   <= '0;
			table_block_count_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_HEADER_LENGTH:     header_length_q     <= pwdata[HDR_W-1:0];
				REG_CONSOLE_SIGNED:    console_signed_q    <= pwdata[0];
				REG_SEPARATION_BIT:    separation_bit_q    <= pwdata[0];
				REG_TABLE_BLOCK_RAW:   table_block_raw_q   <= pwdata[BLK_W-1:0];
				REG_TABLE_BLOCK_COUNT: table_block_count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (reg_idx)
			REG_HEADER_LENGTH:     prdata = DATA_W'(header_length_q);
			REG_CONSOLE_SIGNED:    prdata = DATA_W'(console_signed_q);
			REG_SEPARATION_BIT:    prdata = DATA_W'(separation_bit_q);
			REG_TABLE_BLOCK_RAW:   prdata = DATA_W'(table_block_raw_q);
			REG_TABLE_BLOCK_COUNT: prdata = DATA_W'(table_block_count_q);
			default:               prdata = '0;
		endcase
	end

	// Header end rounded up to the 4 KiB boundary
	assign hdr_pages = {1'b0, header_length_q[HDR_W-1:HDR_ALIGN_LOG2]}
		+ (HDR_W-HDR_ALIGN_LOG2+1)'(|header_length_q[HDR_ALIGN_LOG2-1:0]);
	assign header_end = {hdr_pages, {HDR_ALIGN_LOG2{1'b0}}};

	// Shift is one at the special header end, else chosen by the separation bit
	assign shift_one = (header_end == HEND_W'(SPECIAL_END)) || !separation_bit_q;

	assign cfg.header_end        = header_end;
	assign cfg.term_double       = console_signed_q && shift_one;
	assign cfg.table_block_raw   = table_block_raw_q;
	assign cfg.table_block_count = table_block_count_q;

endmodule

/* rtl/pbat_quot.sv */
// ----------------------------------------------------------------------------
// pbat_quot
// Divides the block number by the three level spans with reciprocal
// multipliers; exact over the whole 24-bit range.
// ----------------------------------------------------------------------------
module pbat_quot
	import pbat_pkg::*;
(
	input  logic [BLK_W-1:0] blk,
	output quot_t            quot
);

	logic [PROD_W-1:0] prod1;
	logic [PROD_W-1:0] prod2;
	logic [PROD_W-1:0] prod3;

	// Three independent multiplies by the reciprocals
	assign prod1 = PROD_W'(blk) * PROD_W'(RECIP1);
	assign prod2 = PROD_W'(blk) * PROD_W'(RECIP2);
	assign prod3 = PROD_W'(blk) * PROD_W'(RECIP3);

	// Drop the fraction
	assign quot.q1 = TERM_W'(prod1 >> RSH1);
	assign quot.q2 = TERM_W'(prod2 >> RSH2);
	assign quot.q3 = TERM_W'(prod3 >> RSH3);

endmodule

/* rtl/package_block_address_translate.sv */
// ----------------------------------------------------------------------------
// package_block_address_translate
// Logical block number to physical block number and package byte offset,
// skipping the hash table blocks of three levels and the file table blocks.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  in       | in_valid/in_stall  | command, logical_block
//  out      | out_valid/out_stall| physical_block, byte_offset, out_of_range
//  config   | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
//  One request per clock when the output is not stalled; out_valid rises once
//  the request has passed one register per step: input register, reciprocal
//  multiply, level sum, file table adjust, offset compute. The reciprocal
//  multipliers and the level sum adder set the stage timing.
//  Each stage holds when the next one is full and stalled; empty stages
//  fill, so in_stall rises only when every stage holds a request.
//  Reset clears all valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module package_block_address_translate
	import pbat_pkg::*;
#(
	parameter int BLOCK_BYTES_LOG2 = BLOCK_BYTES_LOG2_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// Input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic [BLK_W-1:0]  logical_block,
	// Output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PHYS_W-1:0] physical_block,
	output logic [OFFS_W-1:0] byte_offset,
	output logic              out_of_range
);

	`include "package_block_address_translate_assert.svh"

	cfg_t  cfg;
	quot_t quot;

	// Stage valids and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	// Stage payloads
	logic              cmd_s1, cmd_s2, cmd_s3;
	logic [BLK_W-1:0]  blk_s1, blk_s2;
	quot_t             quot_s2;
	logic [PHYS_W-1:0] sum_s3;
	logic [PHYS_W-1:0] phys_s4;
	logic [PHYS_W-1:0] phys_s5;
	logic [OFFS_W-1:0] offs_s5;
	logic              oor_s5;

	// Combinational stage results
	logic [TERM_W-1:0] t1, t2, t3;
	logic [PHYS_W-1:0] sum_d;
	logic              table_hit;
	logic [PHYS_W-1:0] phys_d;
	logic              oor_d;
	logic [OFFS_W-1:0] offs_d;

	pbat_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// Pipeline flow control: a stage loads when empty or when it moves on
	assign rdy_s5   = !v_s5 || !out_stall;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// Stage 1: input register
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			cmd_s1 <= command;
			blk_s1 <= logical_block;
		end
	end

	// Stage 2: level quotients
	pbat_quot u_quot (
		.blk  (blk_s1),
		.quot (quot)
	);

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			cmd_s2  <= cmd_s1;
			blk_s2  <= blk_s1;
			quot_s2 <= quot;
		end
	end

	// Stage 3: level terms and their sum
	always_comb begin
		t1 = (quot_s2.q1 + TERM_W'(1)) << cfg.term_double;
		t2 = (blk_s2 > BLK_W'(LEVEL1)) ? (quot_s2.q2 + TERM_W'(1)) << cfg.term_double : '0;
		t3 = (blk_s2 > BLK_W'(LEVEL2)) ? (quot_s2.q3 + TERM_W'(1)) << cfg.term_double : '0;
		sum_d = PHYS_W'(blk_s2) + PHYS_W'(t1) + PHYS_W'(t2) + PHYS_W'(t3);
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			cmd_s3 <= cmd_s2;
			sum_s3 <= sum_d;
		end
	end

	// Stage 4: file table skip on a file start request
	assign table_hit = cmd_s3 && (sum_s3 == PHYS_W'(cfg.table_block_raw));
	assign phys_d    = table_hit ? sum_s3 + PHYS_W'(cfg.table_block_count) : sum_s3;

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			phys_s4 <= phys_d;
		end
	end

	// Stage 5: range check and byte offset
	assign oor_d  = phys_s4 > PHYS_W'(PHYS_MAX);
	assign offs_d = oor_d ? '1
		: OFFS_W'(cfg.header_end) + (OFFS_W'(phys_s4) << BLOCK_BYTES_LOG2);

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			phys_s5 <= phys_s4;
			offs_s5 <= offs_d;
			oor_s5  <= oor_d;
		end
	end

	assign out_valid      = v_s5;
	assign physical_block = phys_s5;
	assign byte_offset    = offs_s5;
	assign out_of_range   = oor_s5;

	// Checks
	`PBAT_ASSERT_IMPLY(a_oor_offset, clk, arst_n, out_valid && out_of_range, &byte_offset, "out of range result without all-ones offset")
	`PBAT_ASSERT_IMPLY(a_empty_no_stall, clk, arst_n, !out_valid, !in_stall, "input stalled while result register is empty")
	`PBAT_ASSERT_NEXT(a_accept_loads, clk, arst_n, in_valid && !in_stall, v_s1, "accepted request not captured in input register")

endmodule

/* bench/pbat_tb_pkg.sv */
// ----------------------------------------------------------------------------
// pbat_tb_pkg
// Request codes shared by the address translator bench and its checker.
// ----------------------------------------------------------------------------
package pbat_tb_pkg;

	// Request kinds on the input channel
	typedef enum logic {
		CMD_DATA       = 1'b0,
		CMD_FILE_START = 1'b1
	} xlat_cmd_e;

endpackage

/* bench/pbat_checker.sv */
// ----------------------------------------------------------------------------
// pbat_checker
// Watches the configuration port and both request channels of the address
// translator, computes the translation of every accepted request and matches
// it, in order, against the results the block hands out.
// ----------------------------------------------------------------------------
module pbat_checker
	import pbat_pkg::*;
	import pbat_tb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              command,
	input  logic [BLK_W-1:0]  logical_block,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [PHYS_W-1:0] physical_block,
	input  logic [OFFS_W-1:0] byte_offset,
	input  logic              out_of_range,
	output int unsigned       fail_count,
	output int unsigned       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [PHYS_W-1:0] phys;
		logic [OFFS_W-1:0] offs;
		logic              oor;
	} xlat_t;

	// Shadow copy of the settings, taken from the config port
	logic [HDR_W-1:0] hdr_len;
	logic             signed_pkg;
	logic             sep_bit;
	logic [BLK_W-1:0] ft_raw;
	logic [CNT_W-1:0] ft_count;

	// Translations still owed by the block, oldest first
	xlat_t awaited[$];

	// Logical block to physical block and package byte offset
	function automatic xlat_t translate_block(input xlat_cmd_e cmd, input logic [BLK_W-1:0] blk);
		logic [31:0] hdr_end;
		logic [31:0] lblk;
		logic [31:0] phys;
		int unsigned dbl;
		xlat_t r;
		hdr_end = (32'(hdr_len) + 32'hFFF) & 32'hFFFF_F000;
		lblk = 32'(blk);
		// level terms doubled only on console-signed packages; 0xB000 header end forces it
		if (!signed_pkg)
			dbl = 0;
		else if (hdr_end == 32'(SPECIAL_END))
			dbl = 1;
		else
			dbl = sep_bit ? 0 : 1;
		phys = lblk + ((lblk / LEVEL1 + 1) << dbl);
		if (lblk > LEVEL1)
			phys += (lblk / LEVEL2 + 1) << dbl;
		if (lblk > LEVEL2)
			phys += (lblk / LEVEL3 + 1) << dbl;
		// file start landing on the raw file table block skips the table
		if (cmd == CMD_FILE_START && phys == 32'(ft_raw))
			phys += 32'(ft_count);
		r.phys = phys[PHYS_W-1:0];
		r.oor  = (phys > 32'(PHYS_MAX));
		r.offs = r.oor ? '1 : hdr_end + (phys << BLOCK_BYTES_LOG2_DEF);
		return r;
	endfunction

	// Config snoop, prediction on input accept, compare on output accept
	always @(posedge clk or negedge arst_n) begin
		xlat_t want;
		xlat_t got;
		logic  bad;
		if (!arst_n) begin
			hdr_len    = '0;
			signed_pkg = 1'b0;
			sep_bit    = 1'b0;
			ft_raw     = '0;
			ft_count   = '0;
			awaited.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_HEADER_LENGTH:     hdr_len    = pwdata[HDR_W-1:0];
					REG_CONSOLE_SIGNED:    signed_pkg = pwdata[0];
					REG_SEPARATION_BIT:    sep_bit    = pwdata[0];
					REG_TABLE_BLOCK_RAW:   ft_raw     = pwdata[BLK_W-1:0];
					REG_TABLE_BLOCK_COUNT: ft_count   = pwdata[CNT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = '{physical_block, byte_offset, out_of_range};
				if (awaited.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result with no request pending: phys %h offs %h oor %b",
							$realtime, got.phys, got.offs, got.oor);
				end else begin
					want = awaited.pop_front();
					bad = (got.phys !== want.phys) || (got.offs !== want.offs) ||
						(got.oor !== want.oor);
					if (bad) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch phys %h/%h offs %h/%h oor %b/%b (exp/got)",
								$realtime, want.phys, got.phys, want.offs, got.offs,
								want.oor, got.oor);
					end
				end
			end
			if (in_valid && !in_stall)
				awaited.push_back(translate_block(xlat_cmd_e'(command), logical_block));
			outstanding = awaited.size();
		end
	end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Bench for the package block address translator: directed requests at the
// hash level borders, range limits and file table skip, then random requests
// over a series of register settings, with random stalls on both channels
// and one long output hold-off. The checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb_top;
	import pbat_pkg::*;
	import pbat_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic              command;
	logic [BLK_W-1:0]  logical_block;
	logic              out_valid;
	logic              out_stall;
	logic [PHYS_W-1:0] physical_block;
	logic [OFFS_W-1:0] byte_offset;
	logic              out_of_range;
	int unsigned       fail_count;
	int unsigned       outstanding;

	// no idling on either side while set
	bit calm = 1'b0;
	// asks the sink for one long hold-off
	bit hold_request = 1'b0;

	always #5ns clk = ~clk;

	package_block_address_translate u_top (.*);

	pbat_checker u_checker (.*);

	// Offer one request, with random idle cycles ahead of it
	task automatic send_request(input xlat_cmd_e cmd, input logic [BLK_W-1:0] blk);
		while (!calm && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		logical_block <= blk;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Stop offering and wait until every result is back
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// Setup and access cycle of one register write
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_settings(input logic [HDR_W-1:0] hdr, input logic csk,
		input logic sep, input logic [BLK_W-1:0] raw, input logic [CNT_W-1:0] cnt);
		write_reg(REG_HEADER_LENGTH, DATA_W'(hdr));
		write_reg(REG_CONSOLE_SIGNED, DATA_W'(csk));
		write_reg(REG_SEPARATION_BIT, DATA_W'(sep));
		write_reg(REG_TABLE_BLOCK_RAW, DATA_W'(raw));
		write_reg(REG_TABLE_BLOCK_COUNT, DATA_W'(cnt));
	endtask

	// Result side: random stalls, one long hold-off on request
	initial begin : result_sink
		int unsigned held;
		held = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && held < 80) begin
				out_stall <= 1'b1;
				held++;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 34);
			end
		end
	end

	initial begin : stimulus
		logic [HDR_W-1:0] hdr;
		logic             csk;
		logic             sep;
		logic [BLK_W-1:0] raw;
		logic [CNT_W-1:0] cnt;
		logic [BLK_W-1:0] blk;
		xlat_cmd_e        cmd;
		int unsigned      sel;
		int unsigned      back;
		int unsigned      guard;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		command       = CMD_DATA;
		logical_block = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: level borders and field extremes
		send_request(CMD_DATA, 24'd0);
		send_request(CMD_FILE_START, 24'd0);
		send_request(CMD_DATA, 24'd1);
		send_request(CMD_DATA, 24'd169);
		send_request(CMD_DATA, 24'd170);
		send_request(CMD_DATA, 24'd171);
		send_request(CMD_DATA, 24'd28899);
		send_request(CMD_DATA, 24'd28900);
		send_request(CMD_DATA, 24'd28901);
		send_request(CMD_DATA, 24'd4912999);
		send_request(CMD_DATA, 24'd4913000);
		send_request(CMD_DATA, 24'd4913001);
		send_request(CMD_DATA, '1);
		send_request(CMD_FILE_START, '1);

		// Largest header, separation bit set: no doubling; block 170 lands on 172
		wait_idle();
		program_settings('1, 1'b1, 1'b1, 24'd172, '1);
		send_request(CMD_FILE_START, 24'd170);
		send_request(CMD_DATA, 24'd170);
		send_request(CMD_FILE_START, 24'h80_0000);

		// Header end at 0xB000 forces doubled terms; block 0 lands on 2
		wait_idle();
		program_settings(20'hB000, 1'b1, 1'b1, 24'd2, 16'd1);
		send_request(CMD_FILE_START, 24'd0);
		send_request(CMD_DATA, '1);

		// Rounded-up header reaching 0xB000, raw table at its maximum
		wait_idle();
		program_settings(20'hA001, 1'b1, 1'b0, '1, '0);
		send_request(CMD_FILE_START, '1);
		send_request(CMD_DATA, 24'd8300000);

		// Random phases, each with its own settings
		for (int ph = 0; ph < 10; ph++) begin
			wait_idle();
			case ($urandom_range(3))
				0: hdr = '0;
				1: hdr = '1;
				2: hdr = HDR_W'($urandom_range(20'hB000, 20'hA001));
				default: hdr = HDR_W'($urandom);
			endcase
			csk = 1'($urandom_range(1));
			sep = 1'($urandom_range(1));
			raw = ($urandom_range(3) == 0) ? BLK_W'($urandom) : BLK_W'($urandom_range(3000));
			cnt = CNT_W'($urandom);
			if (ph == 0) begin
				hdr = '1;
				csk = 1'b1;
				sep = 1'b1;
				raw = '1;
				cnt = '1;
			end else if (ph == 1) begin
				hdr = '0;
				csk = 1'b0;
				sep = 1'b0;
				raw = '0;
				cnt = '0;
			end
			program_settings(hdr, csk, sep, raw, cnt);
			calm = (ph == 3);
			if (ph == 5)
				hold_request = 1'b1;
			repeat (80) begin
				sel = $urandom_range(99);
				cmd = xlat_cmd_e'($urandom_range(1));
				if (sel < 30) begin
					blk = BLK_W'($urandom);
				end else if (sel < 50) begin
					case ($urandom_range(2))
						0: blk = BLK_W'(LEVEL1);
						1: blk = BLK_W'(LEVEL2);
						default: blk = BLK_W'(LEVEL3);
					endcase
					blk = blk - BLK_W'(2) + BLK_W'($urandom_range(4));
				end else if (sel < 85) begin
					// just below the raw table block, where a file start can land on it
					cmd  = CMD_FILE_START;
					back = $urandom_range(32'(raw) / 80 + 4);
					blk  = (back > 32'(raw)) ? '0 : raw - BLK_W'(back);
				end else begin
					case ($urandom_range(2))
						0: blk = '0;
						1: blk = '1;
						default: blk = BLK_W'($urandom_range(8400000, 8250000));
					endcase
				end
				send_request(cmd, blk);
			end
			calm = 1'b0;
		end

		// Drain, then give the pipeline time to show stray results
		in_valid <= 1'b0;
		guard = 0;
		while (outstanding != 0 && guard < 2000) begin
			@(negedge clk);
			guard++;
		end
		repeat (10) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("PASS package_block_address_translate");
		else
			$display("FAIL package_block_address_translate");
		$finish;
	end

	// Run limit
	initial begin : watchdog
		#2ms;
		$display("FAIL package_block_address_translate");
		$finish;
	end

endmodule
